>>> sv/skf_pkg.sv
// Shared types, constants and the control-store program of the scalar Kalman filter.
package skf_pkg;

	localparam int STEP_W = 4;
	localparam int OP_W   = 4;
	localparam int ADDR_W = 3;
	localparam int CNT_W  = 5;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [OP_W-1:0]   op_t;

	// datapath operations
	localparam op_t OP_NOP    = 4'd0;
	localparam op_t OP_LOAD   = 4'd1;
	localparam op_t OP_PRIOR  = 4'd2;
	localparam op_t OP_SETUP  = 4'd3;
	localparam op_t OP_DIV    = 4'd4;
	localparam op_t OP_KFIX   = 4'd5;
	localparam op_t OP_MULLO  = 4'd6;
	localparam op_t OP_MULHI  = 4'd7;
	localparam op_t OP_MULCOV = 4'd8;
	localparam op_t OP_WRITE  = 4'd9;
	localparam op_t OP_BAD    = 4'd10;

	// hold conditions
	localparam logic [1:0] W_NONE = 2'd0;
	localparam logic [1:0] W_IN   = 2'd1;
	localparam logic [1:0] W_OUT  = 2'd2;

	// jump conditions
	localparam logic [1:0] J_NEXT   = 2'd0;
	localparam logic [1:0] J_ALWAYS = 2'd1;
	localparam logic [1:0] J_BADCH  = 2'd2;
	localparam logic [1:0] J_LOOP   = 2'd3;

	// program steps
	localparam step_t ST_LOAD   = 4'd0;
	localparam step_t ST_PRIOR  = 4'd1;
	localparam step_t ST_SETUP  = 4'd2;
	localparam step_t ST_DIV    = 4'd3;
	localparam step_t ST_KFIX   = 4'd4;
	localparam step_t ST_MULLO  = 4'd5;
	localparam step_t ST_MULHI  = 4'd6;
	localparam step_t ST_MULCOV = 4'd7;
	localparam step_t ST_WRITE  = 4'd8;
	localparam step_t ST_BAD    = 4'd9;

	// register map
	localparam logic REG_Q = 1'b0;
	localparam logic REG_R = 1'b1;
	localparam logic [31:0] Q_RESET = 32'd335544;
	localparam logic [31:0] R_RESET = 32'd100663296;

	localparam logic [24:0]      ONE_Q24  = 25'h1000000;
	localparam logic [23:0]      HALF_Q24 = 24'h800000;
	localparam logic [CNT_W-1:0] DIV_LAST = 5'd24;

	typedef struct packed {
		op_t        op;
		logic [1:0] wt;
		logic [1:0] jc;
		step_t      target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic ready;
	} ctl_t;

	typedef struct packed {
		logic out_busy;
		logic bad_ch;
		logic loop;
	} dp_stat_t;

	typedef struct packed {
		logic     in_valid;
		dp_stat_t dp;
	} stat_t;

	function automatic uword_t ucode(step_t s);
		uword_t w;
		w = '{op: OP_NOP, wt: W_NONE, jc: J_ALWAYS, target: ST_LOAD};
		unique case (s)
			ST_LOAD:   w = '{op: OP_LOAD,   wt: W_IN,   jc: J_NEXT,   target: ST_LOAD};
			ST_PRIOR:  w = '{op: OP_PRIOR,  wt: W_NONE, jc: J_BADCH,  target: ST_BAD};
			ST_SETUP:  w = '{op: OP_SETUP,  wt: W_NONE, jc: J_NEXT,   target: ST_LOAD};
			ST_DIV:    w = '{op: OP_DIV,    wt: W_NONE, jc: J_LOOP,   target: ST_DIV};
			ST_KFIX:   w = '{op: OP_KFIX,   wt: W_NONE, jc: J_NEXT,   target: ST_LOAD};
			ST_MULLO:  w = '{op: OP_MULLO,  wt: W_NONE, jc: J_NEXT,   target: ST_LOAD};
			ST_MULHI:  w = '{op: OP_MULHI,  wt: W_NONE, jc: J_NEXT,   target: ST_LOAD};
			ST_MULCOV: w = '{op: OP_MULCOV, wt: W_NONE, jc: J_NEXT,   target: ST_LOAD};
			ST_WRITE:  w = '{op: OP_WRITE,  wt: W_OUT,  jc: J_ALWAYS, target: ST_LOAD};
			ST_BAD:    w = '{op: OP_BAD,    wt: W_OUT,  jc: J_ALWAYS, target: ST_LOAD};
			default:   w = '{op: OP_NOP,    wt: W_NONE, jc: J_ALWAYS, target: ST_LOAD};
		endcase
		return w;
	endfunction

endpackage

>>> sv/skf_seq.sv
// Microcode sequencer: step counter, control store, hold and jump logic.
module skf_seq import skf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctl_t  ctl
);

	step_t  step_q;
	step_t  step_nxt;
	uword_t uw;
	logic   hold;
	logic   take;

	assign uw = ucode(step_q);

	always_comb begin
		unique case (uw.wt)
			W_IN:    hold = !stat.in_valid;
			W_OUT:   hold = stat.dp.out_busy;
			default: hold = 1'b0;
		endcase
	end

	always_comb begin
		unique case (uw.jc)
			J_ALWAYS: take = 1'b1;
			J_BADCH:  take = stat.dp.bad_ch;
			J_LOOP:   take = stat.dp.loop;
			default:  take = 1'b0;
		endcase
	end

	always_comb begin
		if (hold) begin
			step_nxt = step_q;
		end else if (take) begin
			step_nxt = uw.target;
		end else begin
			step_nxt = step_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_LOAD;
		end else begin
			step_q <= step_nxt;
		end
	end

	assign ctl.op    = hold ? OP_NOP : uw.op;
	assign ctl.ready = (step_q == ST_LOAD);

endmodule

>>> sv/skf_dp.sv
// Filter datapath: per-channel state, restoring divider, shared multiplier, result register.
module skf_dp import skf_pkg::*; #(
	parameter int CHANNELS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_t               ctl,
	input  logic signed [15:0] sample,
	input  logic [1:0]         channel,
	input  logic [31:0]        q_noise,
	input  logic [31:0]        r_noise,
	input  logic               out_stall,
	output logic signed [31:0] estimate,
	output logic [1:0]         axis,
	output logic               out_valid,
	output dp_stat_t           stat
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [31:0] est_q [CHANNELS];
	logic [31:0] cov_q [CHANNELS];

	logic [15:0]      smp_q;
	logic [1:0]       ch_q;
	logic [31:0]      pm_q;
	logic [31:0]      x_q;
	logic [32:0]      denom_q;
	logic [32:0]      rem_q;
	logic [24:0]      nb_q;
	logic [24:0]      quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [32:0]      d_q;
	logic [32:0]      mag_q;
	logic             neg_q;
	logic [24:0]      k_q;
	logic [56:0]      prod_q;
	logic [57:0]      acc_q;
	logic [31:0]      out_est_q;
	logic [1:0]       out_axis_q;
	logic             out_valid_q;

	logic [IDX_W-1:0] idx;
	logic             bad_ch;
	logic [31:0]      cov_sel;
	logic [31:0]      est_sel;
	logic [32:0]      pm_sum;
	logic [33:0]      cand;
	logic [33:0]      diff;
	logic             ge;
	logic [31:0]      mul_a;
	logic [24:0]      mul_b;
	logic [56:0]      mul_p;
	logic [57:0]      acc_rnd;
	logic [33:0]      t_mag;
	logic [33:0]      x_ext;
	logic [33:0]      x_new;
	logic [56:0]      prod_rnd;
	logic [31:0]      p_new;
	logic             out_take;

	assign idx     = IDX_W'(ch_q);
	assign bad_ch  = (32'(ch_q) >= CHANNELS);
	assign cov_sel = bad_ch ? '0 : cov_q[idx];
	assign est_sel = bad_ch ? '0 : est_q[idx];
	assign pm_sum  = {1'b0, cov_sel} + {1'b0, q_noise};

	assign cand = {rem_q, nb_q[24]};
	assign diff = cand - {1'b0, denom_q};
	assign ge   = (cand >= {1'b0, denom_q});

	always_comb begin
		case (ctl.op)
			OP_MULLO: begin
				mul_a = {15'b0, mag_q[16:0]};
				mul_b = k_q;
			end
			OP_MULHI: begin
				mul_a = {16'b0, mag_q[32:17]};
				mul_b = k_q;
			end
			OP_MULCOV: begin
				mul_a = pm_q;
				mul_b = ONE_Q24 - k_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {25'b0, mul_a} * {32'b0, mul_b};

	assign acc_rnd  = acc_q + {34'b0, HALF_Q24};
	assign t_mag    = acc_rnd[57:24];
	assign x_ext    = {{2{x_q[31]}}, x_q};
	assign x_new    = neg_q ? (x_ext - t_mag) : (x_ext + t_mag);
	assign prod_rnd = prod_q + {33'b0, HALF_Q24};
	assign p_new    = prod_rnd[55:24];

	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				est_q[i] <= '0;
				cov_q[i] <= '0;
			end
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.op == OP_SETUP) begin
				cnt_q <= DIV_LAST;
			end else if (ctl.op == OP_DIV) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (ctl.op == OP_WRITE) begin
				est_q[idx] <= x_new[31:0];
				cov_q[idx] <= p_new;
			end
			if (ctl.op == OP_WRITE || ctl.op == OP_BAD) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				smp_q <= sample;
				ch_q  <= channel;
			end
			OP_PRIOR: begin
				pm_q <= pm_sum[32] ? '1 : pm_sum[31:0];
				x_q  <= est_sel;
			end
			OP_SETUP: begin
				denom_q <= {1'b0, pm_q} + {1'b0, r_noise};
				rem_q   <= {2'b0, pm_q[31:1]};
				nb_q    <= {pm_q[0], 24'b0};
				quo_q   <= '0;
				d_q     <= {smp_q[15], smp_q, 16'b0} - {x_q[31], x_q};
			end
			OP_DIV: begin
				rem_q <= ge ? diff[32:0] : cand[32:0];
				quo_q <= {quo_q[23:0], ge};
				nb_q  <= {nb_q[23:0], 1'b0};
			end
			OP_KFIX: begin
				k_q   <= (denom_q == '0) ? '0 : quo_q;
				mag_q <= d_q[32] ? (~d_q + 33'd1) : d_q;
				neg_q <= d_q[32];
			end
			OP_MULLO: begin
				prod_q <= mul_p;
			end
			OP_MULHI: begin
				acc_q  <= {1'b0, prod_q};
				prod_q <= mul_p;
			end
			OP_MULCOV: begin
				acc_q  <= acc_q + {prod_q[40:0], 17'b0};
				prod_q <= mul_p;
			end
			OP_WRITE: begin
				out_est_q  <= x_new[31:0];
				out_axis_q <= ch_q;
			end
			OP_BAD: begin
				out_est_q  <= '0;
				out_axis_q <= ch_q;
			end
			default: begin
			end
		endcase
	end

	assign estimate      = out_est_q;
	assign axis          = out_axis_q;
	assign out_valid     = out_valid_q;
	assign stat.out_busy = out_valid_q && out_stall;
	assign stat.bad_ch   = bad_ch;
	assign stat.loop     = (cnt_q != '0);

endmodule

>>> sv/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter bank: APB registers, sequencer and datapath.
// Transactions are processed one at a time: a new input is not taken until the previous one is written out.
// The gain divider produces its quotient in 25 one-bit steps.
// An unused channel goes from the prior step straight to the result step.
// A finished result waits in the output register while the next transaction is taken.
// Reset clears all channel estimates and covariances and loads Q and R defaults.
module scalar_kalman_filter import skf_pkg::*; #(
	parameter int CHANNELS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample,
	input  logic [1:0]         channel,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] estimate,
	output logic [1:0]         axis,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [31:0] q_noise_q;
	logic [31:0] r_noise_q;
	logic        reg_wr;
	ctl_t        ctl;
	dp_stat_t    dp_stat;
	stat_t       stat;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= Q_RESET;
			r_noise_q <= R_RESET;
		end else if (reg_wr) begin
			if (paddr[2] == REG_Q) begin
				q_noise_q <= pwdata;
			end else begin
				r_noise_q <= pwdata;
			end
		end
	end

	assign prdata = (paddr[2] == REG_R) ? r_noise_q : q_noise_q;

	assign stat.in_valid = in_valid;
	assign stat.dp       = dp_stat;
	assign in_stall      = !ctl.ready;

	skf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	skf_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sample    (sample),
		.channel   (channel),
		.q_noise   (q_noise_q),
		.r_noise   (r_noise_q),
		.out_stall (out_stall),
		.estimate  (estimate),
		.axis      (axis),
		.out_valid (out_valid),
		.stat      (dp_stat)
	);

endmodule

>>> sv/skf_checker.sv
// Port-level assertions for the scalar Kalman filter, bound to the top level.
module skf_checker #(
	parameter int CHANNELS = 3
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] estimate,
	input logic [1:0]  axis
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(estimate) && $stable(axis))
		else $error("stalled result changed");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a transaction is in flight");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared the cycle after the input transaction");

	a_unused_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (32'(axis) >= CHANNELS) |-> estimate == '0)
		else $error("unused channel returned a nonzero estimate");

endmodule

bind scalar_kalman_filter skf_checker #(
	.CHANNELS (CHANNELS)
) u_skf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.estimate  (estimate),
	.axis      (axis)
);

>>> tb/sv/skf_checker.sv
// Checker for the scalar Kalman filter: tracks the registers, predicts each estimate and compares.
`timescale 1ns / 1ps
module tb_skf_checker import skf_pkg::*; #(
	parameter int CHANNELS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] sample,
	input  logic [1:0]         channel,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] estimate,
	input  logic [1:0]         axis,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 pending
);

	localparam logic [ADDR_W-1:0] ADDR_Q = {REG_Q, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_R = {REG_R, 2'b00};

	typedef struct packed {
		logic signed [31:0] estimate;
		logic [1:0]         axis;
	} kf_result_t;

	logic [31:0]        noise_q;
	logic [31:0]        noise_r;
	logic signed [31:0] est_mem [CHANNELS];
	logic [31:0]        cov_mem [CHANNELS];
	kf_result_t         estimate_q[$];
	int                 errs;

	function automatic kf_result_t kalman_update(logic signed [15:0] smp, logic [1:0] ch);
		logic [32:0]        prior;
		logic [32:0]        denom;
		logic [63:0]        gain;
		logic [63:0]        mag;
		logic [63:0]        step;
		logic [63:0]        prod;
		logic signed [63:0] x;
		logic signed [63:0] d;
		logic signed [63:0] xn;
		kf_result_t         res;
		res.axis = ch;
		res.estimate = '0;
		if (ch >= CHANNELS) begin
			return res;
		end
		prior = {1'b0, cov_mem[ch]} + {1'b0, noise_q};
		if (prior[32]) begin
			prior = 33'h0FFFFFFFF;
		end
		denom = prior + {1'b0, noise_r};
		gain = (denom == '0) ? 64'd0 : ({31'd0, prior} << 24) / {31'd0, denom};
		x = est_mem[ch];
		d = smp;
		d = (d <<< 16) - x;
		if (d < 0) begin
			mag = -d;
		end else begin
			mag = d;
		end
		step = (mag * gain + {40'd0, HALF_Q24}) >> 24;
		if (d < 0) begin
			xn = x - $signed(step);
		end else begin
			xn = x + $signed(step);
		end
		prod = ({39'd0, ONE_Q24} - gain) * {32'd0, prior[31:0]};
		prod = prod + {40'd0, HALF_Q24};
		cov_mem[ch] = prod[55:24];
		est_mem[ch] = xn[31:0];
		res.estimate = est_mem[ch];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		kf_result_t want;
		kf_result_t got;
		logic [31:0] reg_val;
		if (!arst_n) begin
			noise_q <= Q_RESET;
			noise_r <= R_RESET;
			for (int i = 0; i < CHANNELS; i++) begin
				est_mem[i] = '0;
				cov_mem[i] = '0;
			end
			estimate_q.delete();
			errs = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.estimate = estimate;
				got.axis = axis;
				if (estimate_q.size() == 0) begin
					errs++;
					$display("%0t: unexpected result estimate=%0d axis=%0d", $time, estimate,
						axis);
				end else begin
					want = estimate_q.pop_front();
					if (got.estimate !== want.estimate) begin
						errs++;
						$display("%0t: estimate expected %0d (%h) actual %0d (%h)", $time,
							want.estimate, want.estimate, got.estimate, got.estimate);
					end
					if (got.axis !== want.axis) begin
						errs++;
						$display("%0t: axis expected %0d actual %0d", $time, want.axis,
							got.axis);
					end
				end
			end
			if (in_valid && !in_stall) begin
				estimate_q.push_back(kalman_update(sample, channel));
			end
			if (psel && penable && pready) begin
				reg_val = (paddr == ADDR_R) ? noise_r : noise_q;
				if (pwrite) begin
					if (paddr == ADDR_Q) noise_q <= pwdata;
					if (paddr == ADDR_R) noise_r <= pwdata;
				end else if (prdata !== reg_val) begin
					errs++;
					$display("%0t: register %0d read expected %h actual %h", $time, paddr,
						reg_val, prdata);
				end
			end
			mismatches <= errs;
			pending <= estimate_q.size();
		end
	end

endmodule

>>> tb/sv/tb_scalar_kalman_filter.sv
// Testbench top for the scalar Kalman filter: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_scalar_kalman_filter;
	import skf_pkg::*;

	localparam int CHANNELS = 3;
	localparam int HOLD_LEN = 300;
	localparam int SEGMENTS = 8;
	localparam int SEG_ITEMS = 48;
	localparam logic [ADDR_W-1:0] ADDR_Q = {REG_Q, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_R = {REG_R, 2'b00};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] sample;
	logic [1:0]         channel;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] estimate;
	logic [1:0]         axis;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 mismatches;
	int                 pending;
	int                 send_pct;
	int                 recv_pct;
	int                 hold_req;
	int                 hold_seen;

	scalar_kalman_filter #(.CHANNELS(CHANNELS)) u_top (.*);

	tb_skf_checker #(.CHANNELS(CHANNELS)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_scalar_kalman_filter NOT OK");
		$finish;
	end

	// output side: random stalls, plus a long hold on request
	initial begin
		out_stall <= 1'b0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(logic [ADDR_W-1:0] addr);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_noise(logic [31:0] q, logic [31:0] r);
		drain();
		apb_write(ADDR_Q, q);
		apb_write(ADDR_R, r);
		apb_read(ADDR_Q);
		apb_read(ADDR_R);
	endtask

	task automatic send_sample(logic signed [15:0] smp, logic [1:0] ch);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= smp;
		channel <= ch;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'($signed($urandom_range(0, 20)) - 10);
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [1:0] pick_channel();
		int r;
		r = $urandom_range(0, 9);
		return (r == 9) ? 2'd3 : 2'(r % 3);
	endfunction

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample <= '0;
		channel <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		send_pct <= 0;
		recv_pct <= 0;
		hold_req <= 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, unused channel
		send_sample(16'sd0, 2'd0);
		send_sample(16'sd32767, 2'd0);
		send_sample(-16'sd32768, 2'd1);
		send_sample(-16'sd1, 2'd2);
		send_sample(16'sd100, 2'd3);
		send_sample(-16'sd32768, 2'd3);
		send_sample(16'sd1, 2'd1);
		// unity gain: estimate tracks the sample exactly
		set_noise(32'hFFFFFFFF, 32'h0);
		send_sample(-16'sd32768, 2'd0);
		send_sample(16'sd32767, 2'd1);
		send_sample(16'sd0, 2'd2);
		send_sample(16'sd5, 2'd3);
		// Q and R zero: zero denominator once covariance is gone
		set_noise(32'h0, 32'h0);
		send_sample(16'sd1000, 2'd0);
		send_sample(-16'sd7, 2'd0);
		send_sample(16'sd3, 2'd1);
		send_sample(16'sd3, 2'd1);
		// covariance saturation
		set_noise(32'hFFFFFFFF, 32'hFFFFFFFF);
		send_sample(16'sd32767, 2'd2);
		send_sample(-16'sd32768, 2'd2);
		send_sample(-16'sd1, 2'd2);
		send_sample(16'sd123, 2'd0);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: set_noise(Q_RESET, R_RESET);
				1: set_noise(32'h0, 32'h0);
				2: set_noise(32'hFFFFFFFF, 32'hFFFFFFFF);
				3: set_noise(32'hFFFFFFFF, 32'h0);
				4: set_noise(32'h0, 32'hFFFFFFFF);
				5: set_noise($urandom, $urandom);
				6: set_noise($urandom_range(0, 1 << 24), $urandom_range(0, 1 << 28));
				default: set_noise(Q_RESET, R_RESET);
			endcase
			case (seg % 4)
				0: begin send_pct <= 0; recv_pct <= 0; end
				1: begin send_pct <= 79; recv_pct <= 0; end
				2: begin send_pct <= 0; recv_pct <= 79; end
				default: begin send_pct <= 23; recv_pct <= 23; end
			endcase
			for (int i = 0; i < SEG_ITEMS; i++) begin
				if (seg == 0 && i == 10) begin
					hold_req <= hold_req + 1;
				end
				send_sample(pick_sample(), pick_channel());
			end
		end

		drain();
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb_scalar_kalman_filter OK");
		end else begin
			$display("tb_scalar_kalman_filter NOT OK");
		end
		$finish;
	end

endmodule
